// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/tgcd_pkg.sv =====
package tgcd_pkg;

  localparam int unsigned TS_IN_WIDTH    = 32;
  localparam int unsigned UNIT_OUT_WIDTH = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam logic [TS_IN_WIDTH-1:0] MISSING_RESET = 32'h7FFF_FFFF;

  typedef struct packed {
    logic last;
    logic usable;
  } tgcd_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_GCD  = 2'b10
  } back_state_e;

endpackage

// ===== sv/tgcd_fifo.sv =====
module tgcd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/tgcd_front.sv =====
module tgcd_front #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tgcd_pkg::TS_IN_WIDTH-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tgcd_pkg::TS_IN_WIDTH-1:0]    in_time_i,
  input  logic                                in_last_i,
  input  logic                                queue_full_i,
  output logic                                push_o,
  output tgcd_pkg::tgcd_flags_t               push_flags_o,
  output logic [TIME_WIDTH-1:0]               push_diff_o
);

  localparam logic [TIME_WIDTH-1:0] SIGN_BIT = {1'b1, {(TIME_WIDTH-1){1'b0}}};

  logic [TIME_WIDTH-1:0] missing_q, missing_d;
  logic [TIME_WIDTH-1:0] prev_time_q;
  logic                  prev_valid_q;
  logic [63:0]           now_ext, cfg_ext, miss_reset_ext;
  logic [TIME_WIDTH-1:0] now_time, cfg_time, ord_prev, ord_now;
  logic                  accept, usable;

  assign now_ext        = {{32{in_time_i[31]}}, in_time_i};
  assign cfg_ext        = {{32{cfg_wdata_i[31]}}, cfg_wdata_i};
  assign miss_reset_ext = {{32{tgcd_pkg::MISSING_RESET[31]}}, tgcd_pkg::MISSING_RESET};
  assign now_time       = now_ext[TIME_WIDTH-1:0];
  assign cfg_time       = cfg_ext[TIME_WIDTH-1:0];
  assign missing_d      = cfg_we_i ? cfg_time : missing_q;

  // Offset binary turns the signed order into an unsigned one.
  assign ord_prev = prev_time_q ^ SIGN_BIT;
  assign ord_now  = now_time ^ SIGN_BIT;

  assign usable = prev_valid_q && (now_time != missing_q) && (prev_time_q != missing_q)
                  && (ord_now > ord_prev);

  assign in_ready_o          = !queue_full_i;
  assign accept              = in_valid_i && in_ready_o;
  assign push_o              = accept && (usable || in_last_i);
  assign push_flags_o.last   = in_last_i;
  assign push_flags_o.usable = usable;
  assign push_diff_o         = ord_now - ord_prev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      missing_q    <= miss_reset_ext[TIME_WIDTH-1:0];
      prev_valid_q <= 1'b0;
    end else begin
      missing_q <= missing_d;
      if (accept) begin
        prev_valid_q <= !in_last_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_time_q <= now_time;
    end
  end

endmodule

// ===== sv/tgcd_back.sv =====
`include "assert_macros.svh"

module tgcd_back #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 queue_empty_i,
  input  tgcd_pkg::tgcd_flags_t                queue_flags_i,
  input  logic [TIME_WIDTH-1:0]                queue_diff_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 out_found_o,
  output logic [tgcd_pkg::UNIT_OUT_WIDTH-1:0]  out_unit_o
);

  localparam int unsigned KW = (TIME_WIDTH > 1) ? $clog2(TIME_WIDTH) : 1;

  tgcd_pkg::back_state_e state_q, state_d;

  logic [TIME_WIDTH-1:0] unit_q, unit_d;
  logic                  unit_valid_q, unit_valid_d;
  logic [TIME_WIDTH-1:0] ga_q, ga_d, gb_q, gb_d;
  logic [KW-1:0]         shift_q, shift_d;
  logic                  last_q, last_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_found_q;
  logic [tgcd_pkg::UNIT_OUT_WIDTH-1:0] out_unit_q;
  logic                  load;
  logic                  load_found;
  logic [TIME_WIDTH-1:0] load_unit;
  logic [63:0]           load_unit_ext;

  assign load_unit_ext = 64'(load_unit);

  always_comb begin
    state_d      = state_q;
    unit_d       = unit_q;
    unit_valid_d = unit_valid_q;
    ga_d         = ga_q;
    gb_d         = gb_q;
    shift_d      = shift_q;
    last_d       = last_q;
    pop_o        = 1'b0;
    load         = 1'b0;
    load_found   = 1'b0;
    load_unit    = '0;
    unique case (state_q)
      tgcd_pkg::ST_IDLE: begin
        if (!queue_empty_i && (!queue_flags_i.last || !out_valid_q)) begin
          pop_o = 1'b1;
          if (queue_flags_i.usable && unit_valid_q) begin
            ga_d    = unit_q;
            gb_d    = queue_diff_i;
            shift_d = '0;
            last_d  = queue_flags_i.last;
            state_d = tgcd_pkg::ST_GCD;
          end else begin
            if (queue_flags_i.usable) begin
              unit_d       = queue_diff_i;
              unit_valid_d = 1'b1;
            end
            if (queue_flags_i.last) begin
              load         = 1'b1;
              load_found   = unit_valid_d;
              load_unit    = unit_valid_d ? unit_d : '0;
              unit_d       = '0;
              unit_valid_d = 1'b0;
            end
          end
        end
      end
      tgcd_pkg::ST_GCD: begin
        if (ga_q == gb_q) begin
          unit_d  = ga_q << shift_q;
          state_d = tgcd_pkg::ST_IDLE;
          if (last_q) begin
            load         = 1'b1;
            load_found   = 1'b1;
            load_unit    = unit_d;
            unit_d       = '0;
            unit_valid_d = 1'b0;
          end
        end else if (!ga_q[0] && !gb_q[0]) begin
          ga_d    = ga_q >> 1;
          gb_d    = gb_q >> 1;
          shift_d = shift_q + KW'(1);
        end else if (!ga_q[0]) begin
          ga_d = ga_q >> 1;
        end else if (!gb_q[0]) begin
          gb_d = gb_q >> 1;
        end else if (ga_q > gb_q) begin
          ga_d = ga_q - gb_q;
        end else begin
          gb_d = gb_q - ga_q;
        end
      end
      default: begin
        state_d = tgcd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tgcd_pkg::ST_IDLE;
      unit_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      unit_q       <= '0;
    end else begin
      state_q      <= state_d;
      unit_valid_q <= unit_valid_d;
      out_valid_q  <= out_valid_d;
      unit_q       <= unit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ga_q    <= ga_d;
    gb_q    <= gb_d;
    shift_q <= shift_d;
    last_q  <= last_d;
    if (load) begin
      out_found_q <= load_found;
      out_unit_q  <= load_unit_ext[tgcd_pkg::UNIT_OUT_WIDTH-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_unit_o  = out_unit_q;

  `ASSERT_IMPLIES(a_gcd_operands_nonzero, clk_i, rst_ni, state_q == tgcd_pkg::ST_GCD, (ga_q != '0) && (gb_q != '0))
  `ASSERT_IMPLIES(a_gcd_has_unit, clk_i, rst_ni, state_q == tgcd_pkg::ST_GCD, unit_valid_q)
  `ASSERT_IMPLIES(a_load_slot_free, clk_i, rst_ni, load, !out_valid_q)
  `ASSERT_NEXT(a_last_clears_unit, clk_i, rst_ni, load, !unit_valid_q)

endmodule

// ===== sv/timestamp_gcd_unit.sv =====
// A last beat's result goes through the queue, any GCD run and the output register.
// Throughput: beats that need no GCD pass at one per cycle through a two-entry queue while
// the GCD unit is idle; a last beat waits in the queue while the previous result is still
// held at the output. A difference folded into an existing unit occupies the binary GCD
// unit, which does one shift or subtract per cycle.
// Reset (async, active low) clears the control state and sets missing_code to 0x7FFFFFFF.
module timestamp_gcd_unit #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] time_value
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] time_unit
  output logic        m_axis_tuser_o    // [0] unit_found
);

  localparam int unsigned QW = TIME_WIDTH + $bits(tgcd_pkg::tgcd_flags_t);

  logic                  push, pop, q_full, q_empty;
  tgcd_pkg::tgcd_flags_t push_flags, pop_flags;
  logic [TIME_WIDTH-1:0] push_diff, pop_diff;
  logic [QW-1:0]         pop_data;

  tgcd_front #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_time_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .queue_full_i(q_full),
    .push_o      (push),
    .push_flags_o(push_flags),
    .push_diff_o (push_diff)
  );

  tgcd_fifo #(
    .WIDTH(QW),
    .DEPTH(tgcd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_flags, push_diff}),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  assign pop_flags = pop_data[QW-1:TIME_WIDTH];
  assign pop_diff  = pop_data[TIME_WIDTH-1:0];

  tgcd_back #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .queue_empty_i(q_empty),
    .queue_flags_i(pop_flags),
    .queue_diff_i (pop_diff),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_found_o  (m_axis_tuser_o),
    .out_unit_o   (m_axis_tdata_o)
  );

endmodule

// ===== dv/tgcd_checker.sv =====
`timescale 1ns / 100ps

module tgcd_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tgcd_pkg::TS_IN_WIDTH-1:0]    cfg_wdata_i,
  input  logic                                s_axis_tvalid_i,
  input  logic                                s_axis_tready_i,
  input  logic [tgcd_pkg::TS_IN_WIDTH-1:0]    s_axis_tdata_i,
  input  logic                                s_axis_tlast_i,
  input  logic                                m_axis_tvalid_i,
  input  logic                                m_axis_tready_i,
  input  logic [tgcd_pkg::UNIT_OUT_WIDTH-1:0] m_axis_tdata_i,
  input  logic                                m_axis_tuser_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);

  typedef struct packed {
    logic                                found;
    logic [tgcd_pkg::UNIT_OUT_WIDTH-1:0] unit;
  } unit_result_t;

  unit_result_t                        unit_expect_q[$];
  unit_result_t                        head_result;
  logic [tgcd_pkg::TS_IN_WIDTH-1:0]    missing_code_q;
  logic [tgcd_pkg::TS_IN_WIDTH-1:0]    prev_stamp_q;
  logic                                prev_valid_q;
  logic [tgcd_pkg::UNIT_OUT_WIDTH-1:0] unit_acc_q;
  logic                                unit_valid_q;

  function automatic logic [tgcd_pkg::TS_IN_WIDTH-1:0] gcd_of(
    input logic [tgcd_pkg::TS_IN_WIDTH-1:0] a,
    input logic [tgcd_pkg::TS_IN_WIDTH-1:0] b
  );
    logic [tgcd_pkg::TS_IN_WIDTH-1:0] rem;
    while (b != '0) begin
      rem = a % b;
      a = b;
      b = rem;
    end
    return a;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic clear_unit_state();
    prev_stamp_q = '0;
    prev_valid_q = 1'b0;
    unit_acc_q = '0;
    unit_valid_q = 1'b0;
  endtask

  // A pair counts only when both stamps are present and the later one is strictly
  // greater in signed order; the difference then always fits in the unsigned width.
  task automatic absorb_stamp(input logic [tgcd_pkg::TS_IN_WIDTH-1:0] stamp, input logic last);
    logic [tgcd_pkg::TS_IN_WIDTH-1:0] step;
    unit_result_t                     res;
    if (prev_valid_q && stamp != missing_code_q && prev_stamp_q != missing_code_q &&
        $signed(stamp) > $signed(prev_stamp_q)) begin
      step = stamp - prev_stamp_q;
      unit_acc_q = unit_valid_q ? gcd_of(step, unit_acc_q) : step;
      unit_valid_q = 1'b1;
    end
    prev_stamp_q = stamp;
    prev_valid_q = 1'b1;
    if (last) begin
      res.found = unit_valid_q;
      res.unit = unit_valid_q ? unit_acc_q : '0;
      unit_expect_q = {unit_expect_q, res};
      clear_unit_state();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      missing_code_q = tgcd_pkg::MISSING_RESET;
      clear_unit_state();
      unit_expect_q.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (unit_expect_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: unit %h found %b",
                                    m_axis_tdata_i, m_axis_tuser_i));
        end else begin
          head_result = unit_expect_q.pop_front();
          if (m_axis_tuser_i !== head_result.found) begin
            report_mismatch($sformatf("unit_found is %b, expected %b",
                                      m_axis_tuser_i, head_result.found));
          end
          if (m_axis_tdata_i !== head_result.unit) begin
            report_mismatch($sformatf("time_unit is %h, expected %h",
                                      m_axis_tdata_i, head_result.unit));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        absorb_stamp(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (cfg_we_i) begin
        missing_code_q = cfg_wdata_i;
      end
      pending_o = unit_expect_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 2 * tgcd_pkg::TS_IN_WIDTH + 32;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam int unsigned PHASE_COUNT  = 5;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_e;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic [tgcd_pkg::TS_IN_WIDTH-1:0]    cfg_wdata_i = '0;
  logic                                s_axis_tvalid_i = 1'b0;
  logic                                s_axis_tready_o;
  logic [tgcd_pkg::TS_IN_WIDTH-1:0]    s_axis_tdata_i = '0;
  logic                                s_axis_tlast_i = 1'b0;
  logic                                m_axis_tvalid_o;
  logic                                m_axis_tready_i = 1'b0;
  logic [tgcd_pkg::UNIT_OUT_WIDTH-1:0] m_axis_tdata_o;
  logic                                m_axis_tuser_o;

  int unsigned                         fail_count;
  int unsigned                         pending_results;
  int unsigned                         cycle_count = 0;
  int unsigned                         stamps_sent = 0;
  int unsigned                         burst_left = 0;
  int unsigned                         stall_left = 0;
  int unsigned                         stall_tick = 0;
  int unsigned                         stall_period = 3;
  ready_mode_e                         stall_mode = RDY_ALWAYS;
  logic [tgcd_pkg::TS_IN_WIDTH-1:0]    missing_now = tgcd_pkg::MISSING_RESET;
  logic [tgcd_pkg::TS_IN_WIDTH-1:0]    run_q[$];
  logic [tgcd_pkg::TS_IN_WIDTH-1:0]    code_list[PHASE_COUNT];

  always #5 clk_i = ~clk_i;

  timestamp_gcd_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  tgcd_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_results)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timestamp_gcd_unit regression: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = ready_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
      stall_period = $urandom_range(2, 9);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      RDY_ALWAYS: m_axis_tready_i = 1'b1;
      RDY_COIN:   m_axis_tready_i = 1'($urandom_range(0, 1));
      RDY_SPARSE: m_axis_tready_i = ($urandom_range(0, 5) == 0);
      default:    m_axis_tready_i = (stall_tick % stall_period == 0);
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_stamp(input logic [tgcd_pkg::TS_IN_WIDTH-1:0] stamp, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_axis_tvalid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = stamp;
    s_axis_tlast_i = last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
    stamps_sent++;
  endtask

  task automatic send_run();
    foreach (run_q[i]) send_stamp(run_q[i], i == run_q.size() - 1);
  endtask

  task automatic random_run();
    int unsigned                      len;
    int unsigned                      unit;
    logic                             noisy;
    logic [tgcd_pkg::TS_IN_WIDTH-1:0] stamp;
    logic [tgcd_pkg::TS_IN_WIDTH-1:0] value;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
    noisy = ($urandom_range(0, 9) == 0);
    stamp = $urandom;
    case ($urandom_range(0, 3))
      0:       unit = $urandom_range(1, 16);
      1:       unit = $urandom_range(1, 1000);
      2:       unit = ($urandom >> $urandom_range(4, 31)) + 1;
      default: unit = 1 << $urandom_range(0, 28);
    endcase
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        value = $urandom;
      end else begin
        if (i != 0) begin
          case ($urandom_range(0, 19))
            0:       stamp = stamp - $urandom_range(1, 5000);
            1:       stamp = stamp;
            default: stamp = stamp + unit * $urandom_range(1, 6);
          endcase
        end
        value = ($urandom_range(0, 11) == 0) ? missing_now : stamp;
      end
      send_stamp(value, i == len - 1);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i = 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_missing(input logic [tgcd_pkg::TS_IN_WIDTH-1:0] code);
    cfg_wdata_i = code;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    missing_now = code;
  endtask

  initial begin
    int unsigned target;
    code_list[0] = 32'h8000_0000;
    code_list[1] = 32'h0000_0000;
    code_list[2] = 32'hFFFF_FFFF;
    code_list[3] = $urandom;
    code_list[4] = 32'h7FFF_FFFF;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_q = '{32'h0000_0005};
    send_run();
    run_q = '{32'h8000_0000, 32'h7FFF_FFFE};
    send_run();
    run_q = '{32'h0000_000A, 32'h0000_000A, 32'h0000_0007, 32'h0000_0004};
    send_run();
    run_q = '{32'h0000_0064, 32'h0000_0070, 32'h7FFF_FFFF, 32'h0000_0082,
              32'h0000_0094, 32'h0000_00A0};
    send_run();
    run_q = '{32'h7FFF_FFFF};
    send_run();
    run_q = '{32'hFFFF_FFEC, 32'hFFFF_FFF8, 32'h0000_0004, 32'h8000_0000, 32'hFFFF_FFFE};
    send_run();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      write_missing(code_list[p]);
      if (code_list[p] == '0) begin
        run_q = '{32'h8000_0000, 32'h7FFF_FFFF};
        send_run();
        run_q = '{32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF};
        send_run();
      end
      target = stamps_sent + PHASE_ITEMS;
      while (stamps_sent < target) random_run();
    end

    wait_idle();
    if (fail_count == 0 && pending_results == 0) begin
      $display("timestamp_gcd_unit regression: pass");
    end else begin
      $display("timestamp_gcd_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tgcd_pkg.sv
sv/tgcd_fifo.sv
sv/tgcd_front.sv
sv/tgcd_back.sv
sv/timestamp_gcd_unit.sv
dv/tgcd_checker.sv
dv/tb_top.sv
